### hw/rtl/lru_move_to_front_list_top_macros.svh
// Assertion macros for the move-to-front recency list.
// Used by lru_move_to_front_list_top; expects clk and rst_n in scope.
`ifndef LRU_MOVE_TO_FRONT_LIST_TOP_MACROS_SVH
`define LRU_MOVE_TO_FRONT_LIST_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lmtf_pkg.sv
// Shared constants, types and the cell control struct of the recency list.
// No dependencies; imported by lmtf_cell and lru_move_to_front_list_top.
package lmtf_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int ID_BITS      = 16;
    localparam int MIN_CAPACITY = 20;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W        = 7;

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [IDX_W-1:0]   pos_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [CAP_W-1:0]   cap_t;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Broadcast from the controller to every cell during the update cycle.
    typedef struct packed {
        logic shift_down;   // move-to-front: entries at or above pos, or all on a miss, move one down
        logic shift_up;     // remove: entries at or below pos close the gap
        logic present;      // the key was found in the list
        pos_t pos;          // where it was found
    } lmtf_ctl_t;

endpackage

### hw/rtl/lmtf_cell.sv
// One slot of the recency list: holds an identifier, compares it with the key
// and takes its neighbor's entry on a shift. Depends on lmtf_pkg.
module lmtf_cell (
    input  logic               clk,
    input  lmtf_pkg::pos_t     cell_index,
    input  lmtf_pkg::count_t   list_len,
    input  lmtf_pkg::id_t      key,
    input  lmtf_pkg::id_t      left_id,
    input  lmtf_pkg::id_t      right_id,
    input  lmtf_pkg::lmtf_ctl_t ctl,
    output lmtf_pkg::id_t      entry_id,
    output logic               hit
);
    import lmtf_pkg::*;

    id_t  entry_reg;
    id_t  entry_next;
    logic at_or_above;

    assign at_or_above = (cell_index <= ctl.pos);
    assign hit = (count_t'(cell_index) < list_len) && (entry_reg == key);
    assign entry_id = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_down && (!ctl.present || at_or_above))
        begin
            entry_next = left_id;
        end
        else if (ctl.shift_up && !at_or_above)
        begin
            entry_next = right_id;
        end
        else if (ctl.shift_up && cell_index == ctl.pos)
        begin
            entry_next = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### hw/rtl/lru_move_to_front_list_top.sv
// Move-to-front recency list: top level with the controller and the cell row.
// Depends on lmtf_pkg, lmtf_cell and lru_move_to_front_list_top_macros.svh.
//
// Usage: an item (operation, object_id) is taken at a rising edge where start
// is high and busy is low. Operation 0 moves the identifier to the head of
// the list, operation 1 removes it. Each item gives one result, shown on
// was_present, old_position, evicted_valid, evicted_id and entry_count for
// exactly one cycle while done is high; the receiver cannot hold it off.
// After the accepting edge the block passes through a compare phase, which
// compares the key against every cell at once, and an update phase, which
// shifts the row of cells by one place; done rises after the update phase.
// A new item may be given in the update phase; busy is high in the compare phase.
// Configuration: cfg_write with cfg_data sets the capacity, clamped to the
// range 20 to 64; lowering it drops surplus tail entries at once. Write it
// only while no item is in flight.
// Reset: the list is empty and the capacity is 20; cell contents are
// undefined until written and are never read beyond the list length.
`include "lru_move_to_front_list_top_macros.svh"

module lru_move_to_front_list_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  lmtf_pkg::id_t      object_id,
    input  logic               cfg_write,
    input  lmtf_pkg::cap_t     cfg_data,
    output logic               done,
    output logic               was_present,
    output lmtf_pkg::pos_t     old_position,
    output logic               evicted_valid,
    output lmtf_pkg::id_t      evicted_id,
    output lmtf_pkg::count_t   entry_count
);
    import lmtf_pkg::*;

    typedef enum logic [1:0] {IDLE, COMPARE, UPDATE} phase_t;

    phase_t    phase_reg, phase_next;
    logic      op_reg;
    id_t       key_reg;
    count_t    len_reg, len_next;
    count_t    cap_reg, cap_next;
    logic      present_reg;
    pos_t      pos_reg;
    id_t       tail_reg;

    logic      done_reg;
    logic      was_present_reg;
    pos_t      old_position_reg;
    logic      evicted_valid_reg, evicted_valid_next;
    id_t       evicted_id_reg, evicted_id_next;
    count_t    entry_count_reg;

    logic      accept;
    logic      at_head;
    logic      [MAX_ENTRIES-1:0] hit_vec;
    id_t       entry_ids [MAX_ENTRIES];
    logic      present_c;
    pos_t      pos_c;
    id_t       tail_c;
    count_t    tail_sel;
    lmtf_ctl_t ctl;

    assign busy   = (phase_reg == COMPARE);
    assign accept = start && !busy;
    assign at_head = present_reg && (pos_reg == '0);

    assign ctl.shift_down = (phase_reg == UPDATE) && (op_reg == OP_ACCESS) && !at_head;
    assign ctl.shift_up   = (phase_reg == UPDATE) && (op_reg == OP_REMOVE) && present_reg;
    assign ctl.present    = present_reg;
    assign ctl.pos        = pos_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            lmtf_cell u_cell (
                .clk        (clk),
                .cell_index (IDX_W'(gi)),
                .list_len   (len_reg),
                .key        (key_reg),
                .left_id    ((gi == 0) ? key_reg : entry_ids[(gi == 0) ? 0 : gi - 1]),
                .right_id   (entry_ids[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
                .ctl        (ctl),
                .entry_id   (entry_ids[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // Identifiers are unique in the list, so at most one cell hits and the
    // position can be formed by OR-ing the indexes of hitting cells.
    assign tail_sel = len_reg - count_t'(1);

    always_comb
    begin
        present_c = |hit_vec;
        pos_c     = '0;
        tail_c    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                pos_c = pos_c | IDX_W'(i);
            end
            if (count_t'(i) == tail_sel)
            begin
                tail_c = tail_c | entry_ids[i];
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        len_next           = len_reg;
        cap_next           = cap_reg;
        evicted_valid_next = 1'b0;
        evicted_id_next    = '0;

        unique case (phase_reg)
            IDLE:
            begin
                if (accept)
                begin
                    phase_next = COMPARE;
                end
            end
            COMPARE:
            begin
                phase_next = UPDATE;
            end
            UPDATE:
            begin
                phase_next = accept ? COMPARE : IDLE;
                if (op_reg == OP_REMOVE)
                begin
                    if (present_reg)
                    begin
                        len_next = len_reg - count_t'(1);
                    end
                end
                else if (!present_reg)
                begin
                    // The list never exceeds the capacity, so a full list
                    // drops exactly its old tail entry.
                    if (len_reg >= cap_reg)
                    begin
                        evicted_valid_next = 1'b1;
                        evicted_id_next    = tail_reg;
                    end
                    else
                    begin
                        len_next = len_reg + count_t'(1);
                    end
                end
            end
            default:
            begin
                phase_next = IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_data < CAP_W'(MIN_CAPACITY))
            begin
                cap_next = count_t'(MIN_CAPACITY);
            end
            else if (int'(cfg_data) > MAX_ENTRIES)
            begin
                cap_next = count_t'(MAX_ENTRIES);
            end
            else
            begin
                cap_next = count_t'(cfg_data);
            end
            if (len_reg > cap_next)
            begin
                len_next = cap_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= IDLE;
            len_reg   <= '0;
            cap_reg   <= count_t'(MIN_CAPACITY);
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cap_reg   <= cap_next;
            done_reg  <= (phase_reg == UPDATE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= object_id;
        end
        if (phase_reg == COMPARE)
        begin
            present_reg <= present_c;
            pos_reg     <= present_c ? pos_c : '0;
            tail_reg    <= tail_c;
        end
        if (phase_reg == UPDATE)
        begin
            was_present_reg   <= present_reg;
            old_position_reg  <= pos_reg;
            evicted_valid_reg <= evicted_valid_next;
            evicted_id_reg    <= evicted_id_next;
            entry_count_reg   <= len_next;
        end
    end

    assign done          = done_reg;
    assign was_present   = was_present_reg;
    assign old_position  = old_position_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_id    = evicted_id_reg;
    assign entry_count   = entry_count_reg;

    `LMTF_ASSERT_NOW(a_len_in_cap, 1'b1, len_reg <= cap_reg, "list length exceeds capacity")
    `LMTF_ASSERT_NOW(a_evict_absent, done && evicted_valid, !was_present, "eviction on a hit")
    `LMTF_ASSERT_NEXT(a_done_spaced, done, !done, "results closer than two cycles")
    `LMTF_ASSERT_NEXT(a_busy_single, busy, !busy, "compare phase lasted more than one cycle")

endmodule
